// ----- design/ils_pkg.sv -----
// Shared types and constants for the indexed list store.
package ils_pkg;

    localparam int DEPTH   = 64;
    localparam int ELEM_W  = 32;
    localparam int FUNC_W  = 3;
    localparam int IDX_W   = 7;
    localparam int DATA_W  = 32;
    localparam int CNT_W   = 7;
    localparam int STAT_W  = 2;
    localparam int ADDR_W  = $clog2(DEPTH);

    typedef enum logic [FUNC_W-1:0] {
        F_PUSH   = 3'd0,
        F_POP    = 3'd1,
        F_INSERT = 3'd2,
        F_DELETE = 3'd3,
        F_GET    = 3'd4,
        F_SET    = 3'd5
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_WR_DATA,
        S_GET_RD,
        S_GET_CAP,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic take;
        logic shift_rd;
        logic shift_wr;
        logic wr_data;
        logic get_rd;
        logic get_cap;
        logic out_load;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        t_func op;
        logic  err;
        logic  shift_more;
        logic  out_free;
    } t_sts;

endpackage

// ----- design/ils_if.sv -----
// Valid/ready channel interfaces for request and response beats.
interface ils_in_if;
    logic                          valid;
    logic                          ready;
    logic [ils_pkg::FUNC_W-1:0]    func;
    logic [ils_pkg::IDX_W-1:0]     index;
    logic [ils_pkg::DATA_W-1:0]    data_in;

    modport source (output valid, func, index, data_in, input ready);
    modport sink   (input valid, func, index, data_in, output ready);
endinterface

interface ils_out_if;
    logic                          valid;
    logic                          ready;
    logic [ils_pkg::DATA_W-1:0]    read_data;
    logic [ils_pkg::CNT_W-1:0]     count;
    logic [ils_pkg::STAT_W-1:0]    status;

    modport source (output valid, read_data, count, status, input ready);
    modport sink   (input valid, read_data, count, status, output ready);
endinterface

// ----- design/indexed_list_store_core.sv -----
// Top level of the indexed list store: controller, datapath and channel wiring.
//
//  channel | dir | beat payload                  | handshake
//  --------+-----+-------------------------------+-------------
//  i_in    | in  | func, index, data_in          | valid/ready
//  o_out   | out | read_data, count, status      | valid/ready
//
// One request at a time; i_in.ready is high only while idle.
// Each beat passes decode, then: push/set write the data, get reads and captures,
// insert/delete shift (insert then writes), rejected requests and pop go on; all
// end in done until o_out is free. Shifts move one entry per RAM read/write pair.
// Reset (i_rst_n low, synchronous) empties the list and drops o_out.valid;
// RAM contents are not cleared, only entries below count are ever read.
// A stalled o_out holds its beat; the next result is loaded once it drains.
module indexed_list_store_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ils_in_if.sink    i_in,
    ils_out_if.source o_out
);
    import ils_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // sequencing: decode, shift loop, single writes, get read
    ils_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // request check, element storage and result register
    ils_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_func      (i_in.func),
        .i_index     (i_in.index),
        .i_data_in   (i_in.data_in),
        .i_out_ready (o_out.ready),
        .o_out_valid (o_out.valid),
        .o_read_data (o_out.read_data),
        .o_count     (o_out.count),
        .o_status    (o_out.status),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

// ----- design/ils_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module ils_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/ils_ctrl.sv -----
// Sequencing state machine for the list store.
module ils_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  ils_pkg::t_sts i_sts,
    output ils_pkg::t_cmd o_cmd
);
    import ils_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_DECODE;
            end
            S_DECODE: begin
                if (i_sts.err) begin
                    n_state = S_DONE;
                end else begin
                    unique case (i_sts.op)
                        F_PUSH, F_SET:      n_state = S_WR_DATA;
                        F_INSERT, F_DELETE: n_state = S_SHIFT_RD;
                        F_GET:              n_state = S_GET_RD;
                        default:            n_state = S_DONE;
                    endcase
                end
            end
            S_SHIFT_RD: begin
                if (i_sts.shift_more)          n_state = S_SHIFT_WR;
                else if (i_sts.op == F_INSERT) n_state = S_WR_DATA;
                else                           n_state = S_DONE;
            end
            S_SHIFT_WR: n_state = S_SHIFT_RD;
            S_WR_DATA:  n_state = S_DONE;
            S_GET_RD:   n_state = S_GET_CAP;
            S_GET_CAP:  n_state = S_DONE;
            S_DONE: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd          = '0;
        o_in_ready     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.take = i_in_valid;
            end
            S_SHIFT_RD: o_cmd.shift_rd = i_sts.shift_more;
            S_SHIFT_WR: o_cmd.shift_wr = 1'b1;
            S_WR_DATA:  o_cmd.wr_data  = 1'b1;
            S_GET_RD:   o_cmd.get_rd   = 1'b1;
            S_GET_CAP:  o_cmd.get_cap  = 1'b1;
            S_DONE:     o_cmd.out_load = i_sts.out_free;
            default:    o_cmd          = '0;
        endcase
    end

endmodule

// ----- design/ils_dp.sv -----
// Datapath: request registers, element RAM, count, shift pointer, result register.
module ils_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [ils_pkg::FUNC_W-1:0]   i_func,
    input  logic [ils_pkg::IDX_W-1:0]    i_index,
    input  logic [ils_pkg::DATA_W-1:0]   i_data_in,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [ils_pkg::DATA_W-1:0]   o_read_data,
    output logic [ils_pkg::CNT_W-1:0]    o_count,
    output logic [ils_pkg::STAT_W-1:0]   o_status,
    input  ils_pkg::t_cmd                i_cmd,
    output ils_pkg::t_sts                o_sts
);
    import ils_pkg::*;

    t_func               r_func;
    logic [ADDR_W-1:0]   r_idx;
    logic [ELEM_W-1:0]   r_data;
    t_status             r_status;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    n_cnt;
    logic [ADDR_W-1:0]   r_ptr;
    logic [ADDR_W-1:0]   n_ptr;
    logic [ELEM_W-1:0]   r_get;
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_out_data;
    logic [CNT_W-1:0]    r_out_cnt;
    t_status             r_out_status;

    t_func               in_op;
    t_status             chk_status;
    logic                full;
    logic                empty;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ELEM_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [ELEM_W-1:0]   ram_rdata;

    // request check against the live count
    assign in_op = t_func'(i_func);
    assign full  = (r_cnt == CNT_W'(DEPTH));
    assign empty = (r_cnt == '0);

    always_comb begin
        chk_status = ST_OK;
        case (in_op) inside
            F_PUSH: begin
                if (full) chk_status = ST_FULL;
            end
            F_POP: begin
                if (empty) chk_status = ST_EMPTY;
            end
            F_INSERT: begin
                if (full)                  chk_status = ST_FULL;
                else if (i_index > r_cnt)  chk_status = ST_RANGE;
            end
            F_DELETE, F_GET, F_SET: begin
                if (empty)                 chk_status = ST_EMPTY;
                else if (i_index >= r_cnt) chk_status = ST_RANGE;
            end
            default: chk_status = ST_OK;
        endcase
    end

    always_comb begin
        n_ptr = r_ptr;
        if (i_cmd.take) begin
            n_ptr = (in_op == F_INSERT) ? r_cnt[ADDR_W-1:0] : i_index[ADDR_W-1:0];
        end else if (i_cmd.shift_wr) begin
            n_ptr = (r_func == F_INSERT) ? r_ptr - 1'b1 : r_ptr + 1'b1;
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        if (r_status == ST_OK) begin
            case (r_func) inside
                F_PUSH, F_INSERT: n_cnt = r_cnt + 1'b1;
                F_POP, F_DELETE:  n_cnt = r_cnt - 1'b1;
                default:          n_cnt = r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_func   <= in_op;
            r_idx    <= i_index[ADDR_W-1:0];
            r_data   <= i_data_in[ELEM_W-1:0];
            r_status <= chk_status;
        end
        r_ptr <= n_ptr;
        if (i_cmd.get_cap) begin
            r_get <= ram_rdata;
        end
        if (i_cmd.out_load) begin
            r_out_data   <= (r_func == F_GET && r_status == ST_OK) ? DATA_W'(r_get) : '0;
            r_out_cnt    <= n_cnt;
            r_out_status <= r_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.out_load) begin
                r_cnt       <= n_cnt;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // element RAM: shifts move one entry per read/write pair
    assign ram_re    = i_cmd.shift_rd | i_cmd.get_rd;
    assign ram_raddr = i_cmd.get_rd         ? r_idx :
                       (r_func == F_INSERT) ? r_ptr - 1'b1 : r_ptr + 1'b1;
    assign ram_we    = i_cmd.shift_wr | i_cmd.wr_data;
    assign ram_waddr = i_cmd.shift_wr     ? r_ptr :
                       (r_func == F_PUSH) ? r_cnt[ADDR_W-1:0] : r_idx;
    assign ram_wdata = i_cmd.wr_data ? r_data : ram_rdata;

    ils_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_sts.op         = r_func;
    assign o_sts.err        = (r_status != ST_OK);
    assign o_sts.shift_more = (r_func == F_INSERT) ? (r_ptr != r_idx)
                                                   : (({1'b0, r_ptr} + 1'b1) < r_cnt);
    assign o_sts.out_free   = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;
    assign o_count     = r_out_cnt;
    assign o_status    = r_out_status;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("live count above capacity");

    a_cnt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.out_load |=> $stable(r_cnt))
        else $error("live count moved outside result load");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(i_cmd.out_load))
        else $error("result valid without a load");

    a_shift_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.shift_wr || i_cmd.wr_data) |-> r_status == ST_OK)
        else $error("RAM written for a rejected request");

endmodule
